@@ sv/lbd_pkg.sv @@
package lbd_pkg;

  localparam int unsigned CNT_W      = 20;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned EXT_W      = 22;
  localparam int unsigned LEN_W      = 5;

  localparam logic             CFG_COMPRESSED = 1'b0;
  localparam logic             CFG_OUT_SIZE   = 1'b1;
  localparam logic [1:0]       HEADER_SKIP    = 2'd3;
  localparam logic [3:0]       FLAG_COUNT     = 4'd8;
  localparam logic [EXT_W-1:0] POS_BIAS       = 22'd18;
  localparam logic [LEN_W-1:0] LEN_BIAS       = 5'd3;
  localparam logic [LEN_W-1:0] LEN_MIN        = 5'd3;
  localparam logic [LEN_W-1:0] LEN_MAX        = 5'd18;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_LITERAL,
    PH_POSLO,
    PH_POSHI
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    K_NONE,
    K_BYTE,
    K_REF
  } kind_e;

  typedef struct packed {
    logic take;
    logic ref_fail;
    logic ref_start;
    logic read;
    logic copy;
  } cmd_t;

  typedef struct packed {
    logic  out_free;
    kind_e kind;
    logic  ref_err;
    logic  copy_last;
  } sts_t;

endpackage

@@ sv/lbd_ram.sv @@
module lbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lbd_dp.sv @@
module lbd_dp import lbd_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  logic [7:0]       in_byte_i,
  input  logic             block_last_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             run_last_o,
  output logic             block_end_o,
  output logic             error_o
);

  logic             compressed_q;
  logic [CNT_W-1:0] out_size_q;
  logic [CNT_W-1:0] out_count_q;
  phase_e           phase_q;
  logic [1:0]       header_left_q;
  logic [7:0]       flag_bits_q;
  logic [3:0]       flags_left_q;
  logic [7:0]       pos_low_q;
  logic             stopped_q;
  logic             last_q;
  logic [7:0]       ref_hi_q;
  logic [AW:0]      dist_q;
  logic [LEN_W-1:0] len_q;
  logic             zero_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_bv_q;
  logic             out_rl_q;
  logic             out_be_q;
  logic             out_err_q;

  logic             full;
  logic             halted;
  kind_e            kind;
  logic [7:0]       nop_flags;
  logic [3:0]       nop_left;
  phase_e           nop_phase;
  logic [POS_W-1:0] pos_raw;
  logic [EXT_W-1:0] pos_ext;
  logic [EXT_W-1:0] d0;
  logic [AW-1:0]    dm1;
  logic [AW:0]      dist_new;
  logic [AW-1:0]    rd_addr;
  logic             zero_new;
  logic [7:0]       ram_rdata;
  logic [7:0]       copy_byte;
  logic [CNT_W-1:0] count_inc;
  logic             copy_last;
  logic             out_free;
  logic             emit_byte;
  logic             emit_status;
  logic             emit;
  logic             restart;
  logic             ram_we;
  logic [7:0]       ram_wdata;

  assign full   = out_count_q >= out_size_q;
  assign halted = stopped_q || ((phase_q != PH_HEADER) && full);

  always_comb begin
    if (!compressed_q) begin
      kind = full ? K_NONE : K_BYTE;
    end else if (halted) begin
      kind = K_NONE;
    end else if (phase_q == PH_LITERAL) begin
      kind = K_BYTE;
    end else if (phase_q == PH_POSHI) begin
      kind = K_REF;
    end else begin
      kind = K_NONE;
    end
  end

  always_comb begin
    nop_flags = {1'b0, flag_bits_q[7:1]};
    nop_left  = (flags_left_q != 4'd0) ? flags_left_q - 4'd1 : 4'd0;
    if (nop_left == 4'd0) begin
      nop_phase = PH_FLAG;
    end else if (nop_flags[0]) begin
      nop_phase = PH_LITERAL;
    end else begin
      nop_phase = PH_POSLO;
    end
  end

  // The copy distance is kept as count minus position, reduced into the window.
  assign pos_raw  = {ref_hi_q[7:4], pos_low_q};
  assign pos_ext  = {{(EXT_W-POS_W){pos_raw[POS_W-1]}}, pos_raw} + POS_BIAS;
  assign d0       = {{(EXT_W-CNT_W){1'b0}}, out_count_q} - pos_ext;
  assign dm1      = d0[AW-1:0] - AW'(1);
  assign dist_new = (d0 == '0) ? '0 : {1'b0, dm1} + (AW+1)'(1);

  assign rd_addr   = out_count_q[AW-1:0] - dist_q[AW-1:0];
  assign zero_new  = (dist_q == '0) || (out_count_q < CNT_W'(dist_q));
  assign copy_byte = zero_q ? 8'd0 : ram_rdata;
  assign count_inc = out_count_q + CNT_W'(1);
  assign copy_last = (len_q == LEN_W'(1)) || (count_inc == out_size_q);

  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit_byte   = cmd_i.take && (kind == K_BYTE);
  assign emit_status = cmd_i.take && (kind == K_NONE) && block_last_i;
  assign emit        = emit_byte || emit_status || cmd_i.ref_fail || cmd_i.copy;
  assign restart     = (cmd_i.take && (kind != K_REF) && block_last_i) ||
                       ((cmd_i.ref_fail || (cmd_i.copy && copy_last)) && last_q);

  assign sts_o.out_free  = out_free;
  assign sts_o.kind      = kind;
  assign sts_o.ref_err   = d0[EXT_W-1];
  assign sts_o.copy_last = copy_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compressed_q  <= 1'b1;
      out_size_q    <= '0;
      out_count_q   <= '0;
      phase_q       <= PH_HEADER;
      header_left_q <= HEADER_SKIP;
      flag_bits_q   <= '0;
      flags_left_q  <= '0;
      pos_low_q     <= '0;
      stopped_q     <= 1'b0;
      last_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COMPRESSED: compressed_q <= cfg_data_i[0];
          CFG_OUT_SIZE:   out_size_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        if (kind == K_REF) begin
          last_q <= block_last_i;
        end else if (compressed_q) begin
          stopped_q <= halted;
          if (!halted) begin
            case (phase_q)
              PH_HEADER: begin
                if (header_left_q == 2'd0) begin
                  phase_q <= PH_FLAG;
                end else begin
                  header_left_q <= header_left_q - 2'd1;
                end
              end
              PH_FLAG: begin
                flag_bits_q  <= in_byte_i;
                flags_left_q <= FLAG_COUNT;
                phase_q      <= in_byte_i[0] ? PH_LITERAL : PH_POSLO;
              end
              PH_LITERAL: begin
                flag_bits_q  <= nop_flags;
                flags_left_q <= nop_left;
                phase_q      <= nop_phase;
              end
              PH_POSLO: begin
                pos_low_q <= in_byte_i;
                phase_q   <= PH_POSHI;
              end
              default: ;
            endcase
          end
        end
        if (emit_byte) begin
          out_count_q <= count_inc;
        end
      end
      if (cmd_i.ref_fail) begin
        stopped_q <= 1'b1;
      end
      if (cmd_i.copy) begin
        out_count_q <= count_inc;
        if (copy_last) begin
          flag_bits_q  <= nop_flags;
          flags_left_q <= nop_left;
          phase_q      <= nop_phase;
        end
      end
      if (restart) begin
        out_count_q   <= '0;
        phase_q       <= PH_HEADER;
        header_left_q <= HEADER_SKIP;
        flag_bits_q   <= '0;
        flags_left_q  <= '0;
        pos_low_q     <= '0;
        stopped_q     <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (kind == K_REF)) begin
      ref_hi_q <= in_byte_i;
    end
    if (cmd_i.ref_start) begin
      dist_q <= dist_new;
      len_q  <= {1'b0, ref_hi_q[3:0]} + LEN_BIAS;
    end
    if (cmd_i.read) begin
      zero_q <= zero_new;
    end
    if (cmd_i.copy) begin
      len_q <= len_q - LEN_W'(1);
    end
    if (emit) begin
      out_byte_q <= emit_byte ? in_byte_i : (cmd_i.copy ? copy_byte : 8'd0);
      out_bv_q   <= emit_byte || cmd_i.copy;
      out_rl_q   <= emit_byte || emit_status || cmd_i.ref_fail ||
                    (cmd_i.copy && copy_last);
      out_be_q   <= ((emit_byte || emit_status) && block_last_i) ||
                    ((cmd_i.ref_fail || (cmd_i.copy && copy_last)) && last_q);
      out_err_q  <= cmd_i.ref_fail;
    end
  end

  assign ram_we    = emit_byte || cmd_i.copy;
  assign ram_wdata = emit_byte ? in_byte_i : copy_byte;

  lbd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (out_count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = out_bv_q;
  assign run_last_o   = out_rl_q;
  assign block_end_o  = out_be_q;
  assign error_o      = out_err_q;

`ifndef SYNTHESIS
  a_copy_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.copy |-> (out_count_q < out_size_q) && out_free)
    else $error("Copy beat issued at a full count or a busy output.");

  a_ref_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ref_start |=> (len_q >= LEN_MIN) && (len_q <= LEN_MAX) &&
                        (dist_q <= (AW+1)'(WINDOW_DEPTH)))
    else $error("Reference length or distance out of range.");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_bv_q) |-> (out_byte_q == 8'd0) && out_rl_q)
    else $error("Status-only beat carries data or lacks run end.");
`endif

endmodule

@@ sv/lbd_ctrl.sv @@
module lbd_ctrl import lbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.take = 1'b1;
          if (sts_i.kind == K_REF) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts_i.ref_err) begin
          if (sts_i.out_free) begin
            cmd_o.ref_fail = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.ref_start = 1'b1;
          state_d         = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.copy = 1'b1;
          state_d    = sts_i.copy_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_EMIT))
    else $error("History read not followed by the emit step.");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("Input taken while a reference is in progress.");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.take, cmd_o.ref_fail, cmd_o.ref_start, cmd_o.read, cmd_o.copy}))
    else $error("More than one datapath command in a cycle.");
`endif

endmodule

@@ sv/lzss_block_decoder.sv @@
// LZSS block decoder with a ring history of WINDOW_DEPTH bytes. A byte is taken
// whenever the output register is free and no reference is in progress; header,
// flag, literal, position-low and pass-through bytes each give at most one beat.
// The second byte of a reference is accepted, then the position is checked,
// and then each copied byte takes a history RAM read, then the write of the
// same byte back into the ring and to the output, which waits while the output
// is stalled. The history needs no clearing after reset: positions not yet
// written in the current block read as zero.
module lzss_block_decoder import lbd_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             block_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             run_last_o,
  output logic             block_end_o,
  output logic             error_o
);

  cmd_t cmd;
  sts_t sts;

  lbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbd_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_byte_i    (in_byte_i),
    .block_last_i (block_last_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .block_end_o  (block_end_o),
    .error_o      (error_o)
  );

endmodule
